// File: src/cpu8ie_pkg.sv
// ----------------------------------------------------------------------------
// cpu8ie_pkg
// Types, command and mode codes shared by the instruction execute block.
// ----------------------------------------------------------------------------
package cpu8ie_pkg;

   localparam int ADDRESS_BITS_DEFAULT = 16;

   typedef enum logic [4:0] {
      CMD_POKE = 5'd0,  CMD_PEEK = 5'd1,  CMD_BRK = 5'd2,
      CMD_LDA  = 5'd3,  CMD_LDX  = 5'd4,  CMD_LDY = 5'd5,
      CMD_STA  = 5'd6,  CMD_STX  = 5'd7,  CMD_STY = 5'd8,
      CMD_TAX  = 5'd9,  CMD_TAY  = 5'd10, CMD_TSX = 5'd11,
      CMD_TXA  = 5'd12, CMD_TXS  = 5'd13, CMD_TYA = 5'd14,
      CMD_PHA  = 5'd15, CMD_PHP  = 5'd16, CMD_PLA = 5'd17,
      CMD_PLP  = 5'd18, CMD_DEC  = 5'd19, CMD_DEX = 5'd20,
      CMD_DEY  = 5'd21, CMD_INC  = 5'd22, CMD_INX = 5'd23,
      CMD_INY  = 5'd24, CMD_ADC  = 5'd25, CMD_SBC = 5'd26,
      CMD_AND  = 5'd27, CMD_EOR  = 5'd28, CMD_ORA = 5'd29
   } cmd_type;

   typedef enum logic [3:0] {
      MODE_IMM = 4'd0, MODE_ABS = 4'd1, MODE_ZP = 4'd2, MODE_ABS_X = 4'd3,
      MODE_ABS_Y = 4'd4, MODE_ZP_X = 4'd5, MODE_ZP_Y = 4'd6,
      MODE_IND_X = 4'd7, MODE_IND_Y = 4'd8
   } mode_type;

   localparam logic [7:0] SIGN_BIT  = 8'h80;
   localparam logic [7:0] SP_RESET  = 8'hFF;
   localparam logic [7:0] BRK_MASK  = 8'h10;
   localparam logic [7:0] ONE_BIT   = 8'h20;

   typedef struct packed {
      logic [4:0] command;
      logic [3:0] address_mode;
      logic [7:0] operand_low;
      logic [7:0] operand_high;
      logic [7:0] poke_data;
   } req_type;

   typedef struct packed {
      logic [7:0]  acc_out;
      logic [7:0]  x_out;
      logic [7:0]  y_out;
      logic [7:0]  sp_out;
      logic [7:0]  status_out;
      logic [15:0] effective_address;
      logic [7:0]  data_out;
      logic        wrote_memory;
      logic        halted;
      logic        error;
   } rsp_type;

   // controller -> datapath
   typedef struct packed {
      logic load_req;   // capture request
      logic ptr_lo;     // read pointer low byte
      logic ptr_hi;     // read pointer high byte
      logic operand;    // read operand at effective address
      logic execute;    // update registers, write memory, emit result
   } ctl_type;

   // datapath -> controller
   typedef struct packed {
      logic indirect;
      logic mem_read;
   } sts_type;

endpackage

// File: src/cpu8ie_datapath.sv
// ----------------------------------------------------------------------------
// cpu8ie_datapath
// Register file, byte memory, address generation and ALU.
// ----------------------------------------------------------------------------
module cpu8ie_datapath #(
   parameter int ADDRESS_BITS = cpu8ie_pkg::ADDRESS_BITS_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  cpu8ie_pkg::req_type  req_in,
   input  cpu8ie_pkg::ctl_type  ctl,
   output cpu8ie_pkg::sts_type  sts,
   output cpu8ie_pkg::rsp_type  rsp_out
);

   logic [7:0] mem [0:(1 << ADDRESS_BITS) - 1];

   cpu8ie_pkg::req_type req_ff;
   logic [7:0] a_ff, x_ff, y_ff, sp_ff, fl_ff;
   logic       brk_ff;
   logic [7:0] ptr_ff, ptrh_ff;
   logic [7:0] rd_ff;
   cpu8ie_pkg::rsp_type rsp_ff;

   logic [4:0] cmd;
   logic [3:0] mode;
   logic uses_mem, is_write, is_rmw, err;
   logic [15:0] abs16, ea_mem, ea, ind16;
   logic [7:0] zp_ptr;
   logic [ADDRESS_BITS-1:0] rd_addr, wr_addr;

   assign cmd  = req_ff.command;
   assign mode = req_ff.address_mode;
   assign abs16 = {req_ff.operand_high, req_ff.operand_low};
   assign ind16 = {ptrh_ff, ptr_ff};

   always_comb begin
      uses_mem = (cmd >= cpu8ie_pkg::CMD_LDA && cmd <= cpu8ie_pkg::CMD_STY) ||
                 cmd == cpu8ie_pkg::CMD_DEC || cmd == cpu8ie_pkg::CMD_INC ||
                 cmd >= cpu8ie_pkg::CMD_ADC;
      is_rmw   = cmd == cpu8ie_pkg::CMD_DEC || cmd == cpu8ie_pkg::CMD_INC;
      is_write = (cmd >= cpu8ie_pkg::CMD_STA && cmd <= cpu8ie_pkg::CMD_STY) || is_rmw;
      err = cmd > cpu8ie_pkg::CMD_ORA || (uses_mem && mode > cpu8ie_pkg::MODE_IND_Y) ||
            (is_write && mode == cpu8ie_pkg::MODE_IMM);
   end

   assign zp_ptr = (mode == cpu8ie_pkg::MODE_IND_X) ? req_ff.operand_low + x_ff
                                                     : req_ff.operand_low;

   always_comb begin
      unique case (mode)
         cpu8ie_pkg::MODE_ABS:   ea_mem = abs16;
         cpu8ie_pkg::MODE_ZP:    ea_mem = {8'h00, req_ff.operand_low};
         cpu8ie_pkg::MODE_ABS_X: ea_mem = abs16 + {8'h00, x_ff};
         cpu8ie_pkg::MODE_ABS_Y: ea_mem = abs16 + {8'h00, y_ff};
         cpu8ie_pkg::MODE_ZP_X:  ea_mem = {8'h00, req_ff.operand_low + x_ff};
         cpu8ie_pkg::MODE_ZP_Y:  ea_mem = {8'h00, req_ff.operand_low + y_ff};
         cpu8ie_pkg::MODE_IND_X: ea_mem = ind16;
         cpu8ie_pkg::MODE_IND_Y: ea_mem = ind16 + {8'h00, y_ff};
         default:                ea_mem = 16'h0000;
      endcase
   end

   always_comb begin
      if (cmd == cpu8ie_pkg::CMD_POKE || cmd == cpu8ie_pkg::CMD_PEEK) begin
         ea = abs16;
      end else if (cmd == cpu8ie_pkg::CMD_PHA || cmd == cpu8ie_pkg::CMD_PHP) begin
         ea = {8'h01, sp_ff};
      end else if (cmd == cpu8ie_pkg::CMD_PLA || cmd == cpu8ie_pkg::CMD_PLP) begin
         ea = {8'h01, sp_ff + 8'd1};
      end else if (uses_mem && mode != cpu8ie_pkg::MODE_IMM) begin
         ea = ea_mem;
      end else begin
         ea = 16'h0000;
      end
   end

   assign sts.indirect = !err && uses_mem &&
                         (mode == cpu8ie_pkg::MODE_IND_X || mode == cpu8ie_pkg::MODE_IND_Y);
   assign sts.mem_read = !err && ((uses_mem && mode != cpu8ie_pkg::MODE_IMM && !(is_write && !is_rmw)) ||
                         cmd == cpu8ie_pkg::CMD_PEEK || cmd == cpu8ie_pkg::CMD_PLA ||
                         cmd == cpu8ie_pkg::CMD_PLP);

   always_comb begin
      if (ctl.ptr_lo) rd_addr = ADDRESS_BITS'({8'h00, zp_ptr});
      else if (ctl.ptr_hi) rd_addr = ADDRESS_BITS'({8'h00, zp_ptr + 8'd1});
      else rd_addr = ea[ADDRESS_BITS-1:0];
   end

   // execute
   logic [7:0] v, a_in, x_in, y_in, sp_in, fl_in, dout, nzv, op, r;
   logic [8:0] sum;
   logic       brk_in, wr_en, set_nz;
   logic [7:0] status_now;

   assign status_now = fl_ff | cpu8ie_pkg::ONE_BIT | (brk_ff ? cpu8ie_pkg::BRK_MASK : 8'h00);

   always_comb begin
      v = (mode == cpu8ie_pkg::MODE_IMM) ? req_ff.operand_low : rd_ff;
      op = (cmd == cpu8ie_pkg::CMD_SBC) ? ~v : v;
      sum = {1'b0, a_ff} + {1'b0, op} + {8'h00, fl_ff[0]};
      r = sum[7:0];
      a_in = a_ff; x_in = x_ff; y_in = y_ff; sp_in = sp_ff; fl_in = fl_ff;
      brk_in = brk_ff; dout = 8'h00; wr_en = 1'b0; set_nz = 1'b0; nzv = 8'h00;
      if (!err) begin
         unique case (cmd)
            cpu8ie_pkg::CMD_POKE: begin dout = req_ff.poke_data; wr_en = 1'b1; end
            cpu8ie_pkg::CMD_PEEK: dout = rd_ff;
            cpu8ie_pkg::CMD_BRK:  brk_in = 1'b1;
            cpu8ie_pkg::CMD_LDA:  begin a_in = v; nzv = v; set_nz = 1'b1; end
            cpu8ie_pkg::CMD_LDX:  begin x_in = v; nzv = v; set_nz = 1'b1; end
            cpu8ie_pkg::CMD_LDY:  begin y_in = v; nzv = v; set_nz = 1'b1; end
            cpu8ie_pkg::CMD_STA:  begin dout = a_ff; wr_en = 1'b1; end
            cpu8ie_pkg::CMD_STX:  begin dout = x_ff; wr_en = 1'b1; end
            cpu8ie_pkg::CMD_STY:  begin dout = y_ff; wr_en = 1'b1; end
            cpu8ie_pkg::CMD_TAX:  begin x_in = a_ff; nzv = a_ff; set_nz = 1'b1; end
            cpu8ie_pkg::CMD_TAY:  begin y_in = a_ff; nzv = a_ff; set_nz = 1'b1; end
            cpu8ie_pkg::CMD_TSX:  begin x_in = sp_ff; nzv = sp_ff; set_nz = 1'b1; end
            cpu8ie_pkg::CMD_TXA:  begin a_in = x_ff; nzv = x_ff; set_nz = 1'b1; end
            cpu8ie_pkg::CMD_TXS:  sp_in = x_ff;
            cpu8ie_pkg::CMD_TYA:  begin a_in = y_ff; nzv = y_ff; set_nz = 1'b1; end
            cpu8ie_pkg::CMD_PHA:  begin dout = a_ff; wr_en = 1'b1; sp_in = sp_ff - 8'd1; end
            cpu8ie_pkg::CMD_PHP:  begin
               dout = status_now | cpu8ie_pkg::ONE_BIT | cpu8ie_pkg::BRK_MASK;
               wr_en = 1'b1; sp_in = sp_ff - 8'd1;
            end
            cpu8ie_pkg::CMD_PLA:  begin
               sp_in = sp_ff + 8'd1; a_in = rd_ff; nzv = rd_ff; set_nz = 1'b1;
            end
            cpu8ie_pkg::CMD_PLP:  begin sp_in = sp_ff + 8'd1; fl_in = rd_ff & 8'hCF; end
            cpu8ie_pkg::CMD_DEC:  begin
               dout = v - 8'd1; wr_en = 1'b1; nzv = v - 8'd1; set_nz = 1'b1;
            end
            cpu8ie_pkg::CMD_INC:  begin
               dout = v + 8'd1; wr_en = 1'b1; nzv = v + 8'd1; set_nz = 1'b1;
            end
            cpu8ie_pkg::CMD_DEX:  begin x_in = x_ff - 8'd1; nzv = x_in; set_nz = 1'b1; end
            cpu8ie_pkg::CMD_DEY:  begin y_in = y_ff - 8'd1; nzv = y_in; set_nz = 1'b1; end
            cpu8ie_pkg::CMD_INX:  begin x_in = x_ff + 8'd1; nzv = x_in; set_nz = 1'b1; end
            cpu8ie_pkg::CMD_INY:  begin y_in = y_ff + 8'd1; nzv = y_in; set_nz = 1'b1; end
            cpu8ie_pkg::CMD_ADC, cpu8ie_pkg::CMD_SBC: begin
               a_in = r; nzv = r; set_nz = 1'b1;
               fl_in[0] = sum[8];
               fl_in[6] = (((a_ff ^ r) & (op ^ r)) & cpu8ie_pkg::SIGN_BIT) != 8'h00;
            end
            cpu8ie_pkg::CMD_AND:  begin a_in = a_ff & v; nzv = a_in; set_nz = 1'b1; end
            cpu8ie_pkg::CMD_EOR:  begin a_in = a_ff ^ v; nzv = a_in; set_nz = 1'b1; end
            default:              begin a_in = a_ff | v; nzv = a_in; set_nz = 1'b1; end
         endcase
         if (set_nz) begin
            fl_in[7] = nzv[7];
            fl_in[1] = nzv == 8'h00;
         end
      end
   end

   assign wr_addr = ea[ADDRESS_BITS-1:0];

   always_ff @(posedge clock) begin
      if (ctl.load_req) req_ff <= req_in;
      if (ctl.ptr_lo) ptr_ff <= mem[rd_addr];
      if (ctl.ptr_hi) ptrh_ff <= mem[rd_addr];
      if (ctl.operand) rd_ff <= mem[rd_addr];
      if (ctl.execute && wr_en) mem[wr_addr] <= dout;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_ff <= 8'h00; x_ff <= 8'h00; y_ff <= 8'h00;
         sp_ff <= cpu8ie_pkg::SP_RESET; fl_ff <= 8'h00; brk_ff <= 1'b0;
      end else if (ctl.execute) begin
         a_ff <= a_in; x_ff <= x_in; y_ff <= y_in;
         sp_ff <= sp_in; fl_ff <= fl_in; brk_ff <= brk_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.execute) begin
         rsp_ff.acc_out <= a_in;
         rsp_ff.x_out <= x_in;
         rsp_ff.y_out <= y_in;
         rsp_ff.sp_out <= sp_in;
         rsp_ff.status_out <= fl_in | cpu8ie_pkg::ONE_BIT |
                              (brk_in ? cpu8ie_pkg::BRK_MASK : 8'h00);
         rsp_ff.effective_address <= err ? 16'h0000 : 16'(ea[ADDRESS_BITS-1:0]);
         rsp_ff.data_out <= dout;
         rsp_ff.wrote_memory <= wr_en;
         rsp_ff.halted <= brk_in;
         rsp_ff.error <= err;
      end
   end

   assign rsp_out = rsp_ff;

endmodule

// File: src/cpu8ie_control.sv
// ----------------------------------------------------------------------------
// cpu8ie_control
// Sequencer: capture, decode, pointer reads, operand read, execute.
// ----------------------------------------------------------------------------
module cpu8ie_control (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  cpu8ie_pkg::sts_type sts,
   output cpu8ie_pkg::ctl_type ctl,
   output logic                busy,
   output logic                rsp_valid
);

   typedef enum logic [5:0] {
      S_IDLE = 6'b000001, S_DECODE = 6'b000010, S_PTR_LO = 6'b000100,
      S_PTR_HI = 6'b001000, S_READ = 6'b010000, S_EXEC = 6'b100000
   } state_type;

   state_type state_ff, state_in;
   logic      valid_ff;

   always_comb begin
      state_in = state_ff;
      ctl = '0;
      unique case (state_ff)
         S_IDLE: if (start) begin ctl.load_req = 1'b1; state_in = S_DECODE; end
         S_DECODE: begin
            if (sts.indirect) state_in = S_PTR_LO;
            else if (sts.mem_read) state_in = S_READ;
            else state_in = S_EXEC;
         end
         S_PTR_LO: begin ctl.ptr_lo = 1'b1; state_in = S_PTR_HI; end
         S_PTR_HI: begin ctl.ptr_hi = 1'b1; state_in = S_READ; end
         S_READ: begin ctl.operand = 1'b1; state_in = S_EXEC; end
         S_EXEC: begin ctl.execute = 1'b1; state_in = S_IDLE; end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= ctl.execute;
      end
   end

   assign busy = state_ff != S_IDLE;
   assign rsp_valid = valid_ff;

endmodule

// File: src/cpu8_instruction_execute_top.sv
// ----------------------------------------------------------------------------
// cpu8_instruction_execute_top
// Executes one decoded instruction per start pulse and returns one result.
// ----------------------------------------------------------------------------
// An instruction is taken when start is high and busy low. The result appears
// on rsp_data with rsp_valid for one cycle and cannot be stalled. Register-only
// commands pass decode and execute, operand and stack reads add a read state,
// indirect modes first read the pointer bytes (single read port). busy drops
// on the cycle the result is shown, so a new instruction may start then.
module cpu8_instruction_execute_top #(
   parameter int ADDRESS_BITS = cpu8ie_pkg::ADDRESS_BITS_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  cpu8ie_pkg::req_type req_data,
   output logic                rsp_valid,
   output cpu8ie_pkg::rsp_type rsp_data
);

   cpu8ie_pkg::ctl_type ctl;
   cpu8ie_pkg::sts_type sts;

   cpu8ie_control u_control (
      .clock(clock), .reset(reset), .start(start), .sts(sts),
      .ctl(ctl), .busy(busy), .rsp_valid(rsp_valid)
   );

   cpu8ie_datapath #(.ADDRESS_BITS(ADDRESS_BITS)) u_datapath (
      .clock(clock), .reset(reset), .req_in(req_data), .ctl(ctl),
      .sts(sts), .rsp_out(rsp_data)
   );

endmodule
